// File: rtl/core/double_hash_table_engine_unit_macros.svh
// assertion macros shared by the hash table engine rtl
// expects i_clk and i_rst_n in the scope of use
`ifndef DOUBLE_HASH_TABLE_ENGINE_UNIT_MACROS_SVH
`define DOUBLE_HASH_TABLE_ENGINE_UNIT_MACROS_SVH

// property checked on the rising clock, muted while reset is active
`define DHTE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition that must hold in the cycle after a trigger
`define DHTE_ASSERT_NEXT(label, pre, post, msg) \
    `DHTE_ASSERT(label, (pre) |=> (post), msg)

`endif

// File: rtl/core/dhte_pkg.sv
// types and constants of the double hashing table engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dhte_pkg;

    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 10;
    localparam int LOG_SIZE_W = 4;

    localparam logic [LOG_SIZE_W-1:0] LOG_SIZE_RESET = 4'd10;
    localparam logic [KEY_W-1:0]      HASH_MULT      = 32'h58d2d93f;
    localparam logic [KEY_W-1:0]      EMPTY_KEY      = 32'hffffffff;
    localparam int                    START_LSB      = 32;
    localparam int                    STEP_LSB       = 16;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_FOUND     = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_INSERTED  = 3'd2,
        STAT_DUPLICATE = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic hash;
        logic start;
        logic advance;
        logic fin_rsv;
        logic fin_probe;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic reserved;
        logic stop;
        logic wrap;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/core/dhte_channels.sv
// valid/ready channel interfaces: request, response and size register write
// depends on dhte_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dhte_req_if import dhte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, cmd, key, data_in, input ready);
    modport sink   (input valid, cmd, key, data_in, output ready);
endinterface

interface dhte_rsp_if import dhte_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, status, data_out, slot, input ready);
    modport sink   (input valid, status, data_out, slot, output ready);
endinterface

interface dhte_cfg_if import dhte_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LOG_SIZE_W-1:0] log_size;

    modport source (output valid, log_size, input ready);
    modport sink   (input valid, log_size, output ready);
endinterface

`default_nettype wire

// File: rtl/core/double_hash_table_engine_unit.sv
// Open-addressing key/data table with double hashing. After reset the key memory is swept to
// all ones, one slot per cycle, over all 2**MAX_LOG_DEPTH slots (1024 at the default); no
// request is taken during that sweep, size register writes are. A request is then accepted,
// its key is hashed by the multiply, the start slot is formed and the first read issued, and
// then one slot is probed per cycle through the single read port of the key memory. The
// reserved key finishes at its start slot without a probe. The next request is accepted in the
// cycle after a result is registered; a result waits in the output register until taken.
// depends on dhte_pkg, dhte_channels, dhte_ctrl and dhte_datapath
`timescale 1ns / 1ps
`default_nettype none

module double_hash_table_engine_unit
    import dhte_pkg::*;
#(
    parameter int MAX_LOG_DEPTH = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dhte_req_if.sink    i_req,
    dhte_rsp_if.source  o_rsp,
    dhte_cfg_if.sink    i_cfg
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    dhte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    dhte_datapath #(
        .MAX_LOG_DEPTH (MAX_LOG_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_req_cmd      (i_req.cmd),
        .i_req_key      (i_req.key),
        .i_req_data     (i_req.data_in),
        .i_cfg_wr       (cfg_wr),
        .i_cfg_log_size (i_cfg.log_size),
        .o_status       (o_rsp.status),
        .o_data_out     (o_rsp.data_out),
        .o_slot         (o_rsp.slot)
    );

endmodule

`default_nettype wire

// File: rtl/core/dhte_datapath.sv
// datapath: size register, hash multiplier, probe address, key and data memories
// depends on dhte_pkg
`timescale 1ns / 1ps
`default_nettype none

module dhte_datapath
    import dhte_pkg::*;
#(
    parameter int MAX_LOG_DEPTH = 10
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  wire                  i_req_cmd,
    input  wire [KEY_W-1:0]      i_req_key,
    input  wire [DATA_W-1:0]     i_req_data,
    input  wire                  i_cfg_wr,
    input  wire [LOG_SIZE_W-1:0] i_cfg_log_size,
    output logic [STATUS_W-1:0]  o_status,
    output logic [DATA_W-1:0]    o_data_out,
    output logic [SLOT_W-1:0]    o_slot
);

    localparam int IDX_W = MAX_LOG_DEPTH;
    localparam int DEPTH = 1 << MAX_LOG_DEPTH;
    localparam int LG_W  = $clog2(MAX_LOG_DEPTH + 1);

    logic [LOG_SIZE_W-1:0] r_log_size;
    logic [IDX_W-1:0]      r_clr_addr;

    logic              r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_din;
    logic [63:0]       r_prod;
    logic [IDX_W-1:0]  r_mask;
    logic [IDX_W-1:0]  r_start;
    logic [IDX_W-1:0]  r_step;
    logic [IDX_W-1:0]  r_cur;

    logic [KEY_W-1:0]  r_key_mem  [DEPTH];
    logic [DATA_W-1:0] r_data_mem [DEPTH];
    logic [KEY_W-1:0]  r_rd_key;
    logic [DATA_W-1:0] r_rd_data;

    t_status           r_status;
    logic [DATA_W-1:0] r_dout;
    logic [SLOT_W-1:0] r_slot;

    logic [LG_W-1:0]   lg;
    logic [IDX_W-1:0]  n_mask;
    logic [IDX_W-1:0]  n_start;
    logic [IDX_W-1:0]  n_step;
    logic [IDX_W-1:0]  n_next;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  wr_key;
    logic              key_wr;
    logic              data_wr;
    logic              hit;
    logic              empty;

    t_status           n_status;
    logic [DATA_W-1:0] n_dout;
    logic [IDX_W-1:0]  slot_idx;
    logic [SLOT_W+IDX_W-1:0] slot_ext;

    // used size, clamped into the legal range
    always_comb begin
        priority if (r_log_size == '0) begin
            lg = LG_W'(1);
        end else if (int'(r_log_size) > MAX_LOG_DEPTH) begin
            lg = LG_W'(MAX_LOG_DEPTH);
        end else begin
            lg = LG_W'(r_log_size);
        end
    end

    assign n_mask  = ~({IDX_W{1'b1}} << lg);
    assign n_start = r_prod[START_LSB +: IDX_W] & r_mask;
    assign n_step  = (r_prod[STEP_LSB +: IDX_W] | IDX_W'(1)) & r_mask;
    assign n_next  = (r_cur + r_step) & r_mask;

    assign hit   = (r_rd_key == r_key);
    assign empty = (r_rd_key == EMPTY_KEY);

    assign o_sts.clear_last = (r_clr_addr == {IDX_W{1'b1}});
    assign o_sts.reserved   = (r_key == EMPTY_KEY);
    assign o_sts.stop       = hit || empty;
    assign o_sts.wrap       = (n_next == r_start);

    always_comb begin
        priority if (i_cmd.advance) begin
            rd_addr = n_next;
        end else if (i_cmd.start) begin
            rd_addr = n_start;
        end else begin
            rd_addr = r_cur;
        end
    end

    assign data_wr = i_cmd.fin_probe && !hit && empty && (r_cmd == CMD_INSERT);
    assign key_wr  = i_cmd.clear || data_wr;
    assign wr_addr = i_cmd.clear ? r_clr_addr : r_cur;
    assign wr_key  = i_cmd.clear ? EMPTY_KEY : r_key;

    // result of a finished request
    always_comb begin
        n_dout   = '0;
        slot_idx = r_cur;
        priority if (i_cmd.fin_rsv) begin
            n_status = (r_cmd == CMD_INSERT) ? STAT_DUPLICATE : STAT_NOT_FOUND;
            slot_idx = n_start;
        end else if (hit) begin
            if (r_cmd == CMD_INSERT) begin
                n_status = STAT_DUPLICATE;
            end else begin
                n_status = STAT_FOUND;
                n_dout   = r_rd_data;
            end
        end else if (empty) begin
            n_status = (r_cmd == CMD_INSERT) ? STAT_INSERTED : STAT_NOT_FOUND;
        end else begin
            n_status = STAT_FULL;
            slot_idx = r_start;
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_size <= LOG_SIZE_RESET;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_log_size <= i_cfg_log_size;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_req_cmd;
            r_key <= i_req_key;
            r_din <= i_req_data;
        end
        if (i_cmd.hash) begin
            r_prod <= 64'(r_key) * 64'(HASH_MULT);
            r_mask <= n_mask;
        end
        if (i_cmd.start) begin
            r_start <= n_start;
            r_step  <= n_step;
            r_cur   <= n_start;
        end else if (i_cmd.advance) begin
            r_cur <= n_next;
        end
        if (i_cmd.fin_rsv || i_cmd.fin_probe) begin
            r_status <= n_status;
            r_dout   <= n_dout;
            r_slot   <= slot_ext[SLOT_W-1:0];
        end
    end

    // key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_key_mem[wr_addr] <= wr_key;
        end
        r_rd_key <= r_key_mem[rd_addr];
    end

    // data memory, read at the same address as the keys
    always_ff @(posedge i_clk) begin
        if (data_wr) begin
            r_data_mem[r_cur] <= r_din;
        end
        r_rd_data <= r_data_mem[rd_addr];
    end

    assign o_status   = r_status;
    assign o_data_out = r_dout;
    assign o_slot     = r_slot;

endmodule

`default_nettype wire

// File: rtl/core/dhte_ctrl.sv
// controller: clearing sweep, request sequencing and response valid
// depends on dhte_pkg and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "double_hash_table_engine_unit_macros.svh"

module dhte_ctrl
    import dhte_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_req_valid,
    output logic    o_req_ready,
    input  wire     i_rsp_ready,
    output logic    o_rsp_valid,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_START,
        S_PROBE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;
    logic   req_fire;
    logic   finish;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_rsp_ready;
    assign finish      = o_cmd.fin_rsv || o_cmd.fin_probe;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = S_START;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                if (!i_sts.reserved) begin
                    n_state = S_PROBE;
                end else if (out_free) begin
                    o_cmd.fin_rsv = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_PROBE: begin
                if (!i_sts.stop && !i_sts.wrap) begin
                    o_cmd.advance = 1'b1;
                end else if (out_free) begin
                    o_cmd.fin_probe = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;

    `DHTE_ASSERT(a_finish_needs_room, finish |-> out_free, "result finished into a full output")
    `DHTE_ASSERT(a_one_action, $onehot0({o_cmd.clear, o_cmd.advance, o_cmd.fin_rsv, o_cmd.fin_probe}), "conflicting datapath commands")
    `DHTE_ASSERT_NEXT(a_accept_hashes, req_fire, r_state == S_HASH, "accepted request not hashed")
    `DHTE_ASSERT_NEXT(a_finish_shows, finish, r_out_valid, "finished result not presented")

endmodule

`default_nettype wire

// File: test/double_hash_table_engine_unit_tb.sv
// testbench for the double hashing key/data table engine: directed and random lookups and
// inserts over several table sizes, checked against an in-bench model of the probe sequence
// depends on dhte_pkg, dhte_channels and double_hash_table_engine_unit
`timescale 1ns / 1ps

module double_hash_table_engine_unit_tb;
    import dhte_pkg::*;

    localparam int TABLE_LOG_MAX = 10;
    localparam int TABLE_DEPTH   = 1 << TABLE_LOG_MAX;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        t_status           status;
        logic [DATA_W-1:0] data_out;
        logic [SLOT_W-1:0] slot;
    } t_probe_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dhte_req_if req_if ();
    dhte_rsp_if rsp_if ();
    dhte_cfg_if cfg_if ();

    double_hash_table_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    logic [KEY_W-1:0]      key_mem [TABLE_DEPTH];
    logic [DATA_W-1:0]     data_mem[TABLE_DEPTH];
    logic [LOG_SIZE_W-1:0] table_log_size;
    t_probe_result         pending_results[$];
    logic [KEY_W-1:0]      stored_keys[$];
    int                    mismatch_count = 0;
    bit                    req_idle_on = 1'b0;
    bit                    rsp_idle_on = 1'b0;
    bit                    hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    initial begin
        #60_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // walks the probe sequence for one request and applies an insert to the table copy
    function automatic t_probe_result probe_table(input logic cmd, input logic [KEY_W-1:0] key,
                                                  input logic [DATA_W-1:0] din);
        logic [63:0]      product;
        logic [KEY_W-1:0] mask;
        logic [KEY_W-1:0] start;
        logic [KEY_W-1:0] stride;
        logic [KEY_W-1:0] cur;
        int               lg;
        bit               hit;
        bit               empty_slot;
        t_probe_result    r;
        lg = table_log_size;
        if (lg < 1)
            lg = 1;
        if (lg > TABLE_LOG_MAX)
            lg = TABLE_LOG_MAX;
        mask = (32'd1 << lg) - 32'd1;
        product = {32'd0, key} * {32'd0, HASH_MULT};
        start = product[START_LSB +: 32] & mask;
        stride = (product[STEP_LSB +: 32] | 32'd1) & mask;
        cur = start;
        hit = 1'b0;
        empty_slot = 1'b0;
        r.data_out = '0;
        if (key == EMPTY_KEY) begin
            r.status = (cmd == CMD_INSERT) ? STAT_DUPLICATE : STAT_NOT_FOUND;
        end else begin
            do begin
                if (key_mem[cur[SLOT_W-1:0]] == key)
                    hit = 1'b1;
                else if (key_mem[cur[SLOT_W-1:0]] == EMPTY_KEY)
                    empty_slot = 1'b1;
                else
                    cur = (cur + stride) & mask;
            end while (!hit && !empty_slot && cur != start);
            if (!hit && !empty_slot) begin
                r.status = STAT_FULL;
                cur = start;
            end else if (cmd == CMD_LOOKUP) begin
                if (hit) begin
                    r.status = STAT_FOUND;
                    r.data_out = data_mem[cur[SLOT_W-1:0]];
                end else begin
                    r.status = STAT_NOT_FOUND;
                end
            end else if (hit) begin
                r.status = STAT_DUPLICATE;
            end else begin
                key_mem[cur[SLOT_W-1:0]] = key;
                data_mem[cur[SLOT_W-1:0]] = din;
                stored_keys.push_back(key);
                r.status = STAT_INSERTED;
            end
        end
        r.slot = cur[SLOT_W-1:0];
        return r;
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                                input logic [DATA_W-1:0] din);
        int gap;
        gap = (req_idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.cmd     <= cmd;
        req_if.key     <= key;
        req_if.data_in <= din;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_results.push_back(probe_table(cmd, key, din));
        @(negedge i_clk);
    endtask

    task automatic send_random_request(input int insert_pct);
        logic             cmd;
        logic [KEY_W-1:0] key;
        int               pick;
        int               reuse_pct;
        cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_LOOKUP;
        reuse_pct = (cmd == CMD_INSERT) ? 25 : 65;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            key = EMPTY_KEY;
        else if (pick < 4 + reuse_pct && stored_keys.size() > 0)
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else
            key = $urandom();
        send_request(cmd, key, $urandom());
    endtask

    // only while idle: waits out every pending result first
    task automatic write_log_size(input logic [LOG_SIZE_W-1:0] value);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid    <= 1'b1;
        cfg_if.log_size <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        table_log_size = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_basic_ops();
        send_request(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(CMD_INSERT, 32'h0000_0000, 32'hffff_ffff);
        send_request(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_request(CMD_INSERT, 32'hffff_fffe, 32'h0000_0000);
        send_request(CMD_LOOKUP, 32'hffff_fffe, 32'hffff_ffff);
        send_request(CMD_LOOKUP, EMPTY_KEY, 32'h0);
        send_request(CMD_INSERT, EMPTY_KEY, 32'hffff_ffff);
        send_request(CMD_INSERT, 32'h8000_0001, 32'h5a5a_a5a5);
        send_request(CMD_LOOKUP, 32'h8000_0001, 32'h0);
    endtask

    // two slots fill up fast, so probes wrap back to the start
    task automatic test_table_full();
        write_log_size(4'd1);
        send_request(CMD_INSERT, 32'h0000_0001, 32'h1111_1111);
        send_request(CMD_INSERT, 32'h0000_0002, 32'h2222_2222);
        send_request(CMD_INSERT, 32'h0000_0003, 32'h3333_3333);
        send_request(CMD_LOOKUP, 32'h0000_0004, 32'h0);
        send_request(CMD_INSERT, 32'h7fff_ffff, 32'hdead_beef);
        send_request(CMD_LOOKUP, EMPTY_KEY, 32'h0);
    endtask

    task automatic test_size_clamp();
        write_log_size(4'd0);
        send_request(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(CMD_INSERT, 32'h0000_0005, 32'h0505_0505);
        write_log_size(4'd15);
        send_request(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(CMD_LOOKUP, 32'hffff_fffe, 32'h0);
        send_request(CMD_INSERT, 32'hc000_0000, 32'h8000_0000);
    endtask

    task automatic test_output_backpressure();
        write_log_size(4'd10);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (30)
            send_random_request(50);
    endtask

    task automatic test_random_sizes();
        logic [LOG_SIZE_W-1:0] sizes[16];
        int                    phase;
        sizes = '{4'd4, 4'd1, 4'd8, 4'd2, 4'd10, 4'd0, 4'd6, 4'd3,
                  4'd12, 4'd5, 4'd9, 4'd7, 4'd15, 4'd11, 4'd13, 4'd14};
        for (phase = 0; phase < 16; phase++) begin
            write_log_size(sizes[phase]);
            req_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
            rsp_idle_on = (phase % 4 == 0) || (phase % 4 == 3);
            repeat (95)
                send_random_request(30 + 10 * (phase % 4));
        end
    endtask

    // response side: random stalls plus one long hold-off on request
    initial begin
        int rsp_stall_left;
        rsp_stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                rsp_stall_left = HOLD_CYCLES;
            end else if (rsp_stall_left == 0 && rsp_idle_on && $urandom_range(0, 99) < 20) begin
                rsp_stall_left = pick_gap();
            end
            if (rsp_stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                rsp_stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_probe_result exp_r;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: status %0d slot %0d",
                       rsp_if.status, rsp_if.slot);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (rsp_if.status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, rsp_if.status);
                    mismatch_count++;
                end
                if (rsp_if.data_out !== exp_r.data_out) begin
                    $error("data_out expected %08h actual %08h", exp_r.data_out,
                           rsp_if.data_out);
                    mismatch_count++;
                end
                if (rsp_if.slot !== exp_r.slot) begin
                    $error("slot expected %0d actual %0d", exp_r.slot, rsp_if.slot);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        req_if.valid    = 1'b0;
        req_if.cmd      = CMD_LOOKUP;
        req_if.key      = '0;
        req_if.data_in  = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.log_size = LOG_SIZE_RESET;
        i_rst_n         = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            key_mem[i]  = EMPTY_KEY;
            data_mem[i] = '0;
        end
        table_log_size = LOG_SIZE_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_table_full();
        test_size_clamp();
        test_output_backpressure();
        test_random_sizes();

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
